[hdl/fnid_pkg.sv]
// shared constants and types of the four-neighbour impulse denoise filter
package fnid_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;
  localparam int THRESH_W       = 8;
  localparam int OUT_PIX_W      = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd30;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd20;
  localparam logic [THRESH_W-1:0]       THRESH_RESET       = 8'd1;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // position class of one pixel, decided when it is taken in
  typedef struct packed {
    logic has_up;      // row >= 2
    logic has_left;    // column >= 1
    logic has_left2;   // column >= 2
    logic has_right;   // not the last column
    logic emit_above;  // row >= 1: pixel of the row above is finished
    logic emit_left;   // bottom row, column >= 1
    logic emit_end;    // bottom row, last column
  } fnid_flags_t;

  localparam int FLAGS_W = $bits(fnid_flags_t);

endpackage

[hdl/fnid_queue.sv]
// small first-in first-out queue built from registers
module fnid_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] din,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] dout
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= NW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[hdl/fnid_front.sv]
// front end: configuration registers, raster position and per-pixel classification
module fnid_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fnid_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fnid_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic [PIXEL_BITS-1:0]               pixel_in,
  output logic                                q_push,
  input  logic                                q_full,
  output logic [PIXEL_BITS-1:0]               q_pix,
  output logic [$clog2(MAX_WIDTH)-1:0]        q_col,
  output fnid_pkg::fnid_flags_t               q_flags,
  output logic [fnid_pkg::THRESH_W-1:0]       diff_threshold
);
  import fnid_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
  localparam logic [HW-1:0] H_MAX = HW'(MAX_HEIGHT);

  logic [IMAGE_WIDTH_W-1:0]  image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;
  logic [CW-1:0]             col;
  logic [RW-1:0]             row;
  logic [WW-1:0]             eff_w;
  logic [HW-1:0]             eff_h;
  logic [WW-1:0]             col_p1;
  logic [HW-1:0]             row_p1;
  logic                      last_col;
  logic                      last_row;
  logic                      accept;
  logic                      cfg_hit;

  // out-of-range sizes act as the nearest legal size
  always_comb begin
    if (image_width < IMAGE_WIDTH_W'(2)) begin
      eff_w = WW'(2);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = W_MAX;
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height < IMAGE_HEIGHT_W'(2)) begin
      eff_h = HW'(2);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_h = H_MAX;
    end else begin
      eff_h = HW'(image_height);
    end
  end

  always_comb begin
    case (cfg_index)
      REG_IMAGE_WIDTH:    cfg_hit = cfg_write;
      REG_IMAGE_HEIGHT:   cfg_hit = cfg_write;
      REG_DIFF_THRESHOLD: cfg_hit = cfg_write;
      default:            cfg_hit = 1'b0;
    endcase
  end

  assign col_p1   = WW'(col) + WW'(1);
  assign row_p1   = HW'(row) + HW'(1);
  assign last_col = (col_p1 == eff_w);
  assign last_row = (row_p1 == eff_h);

  assign accept = push && !q_full;
  assign full   = q_full;
  assign q_push = accept;
  assign q_pix  = pixel_in;
  assign q_col  = col;

  always_comb begin
    q_flags.has_up     = (row != '0) && (row != RW'(1));
    q_flags.has_left   = (col != '0);
    q_flags.has_left2  = (col != '0) && (col != CW'(1));
    q_flags.has_right  = !last_col;
    q_flags.emit_above = (row != '0);
    q_flags.emit_left  = last_row && (col != '0);
    q_flags.emit_end   = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= IMAGE_WIDTH_RESET;
      image_height   <= IMAGE_HEIGHT_RESET;
      diff_threshold <= THRESH_RESET;
      col            <= '0;
      row            <= '0;
    end else if (cfg_hit) begin
      // a write to any of the three defined registers restarts the frame
      col <= '0;
      row <= '0;
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[IMAGE_HEIGHT_W-1:0];
        REG_DIFF_THRESHOLD: diff_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : RW'(row_p1);
      end else begin
        col <= CW'(col_p1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (WW'(col) < eff_w) && (HW'(row) < eff_h))
    else $error("raster position outside the frame");

endmodule

[hdl/fnid_back.sv]
// back end: line buffer memory, neighbour selection and the outlier decision
module fnid_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_empty,
  output logic                               in_pop,
  input  logic [PIXEL_BITS-1:0]              in_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0]       in_col,
  input  fnid_pkg::fnid_flags_t              in_flags,
  input  logic [fnid_pkg::THRESH_W-1:0]      diff_threshold,
  input  logic                               out_full,
  output logic                               out_push,
  output logic [PIXEL_BITS-1:0]              out_pix,
  output logic                               out_replaced,
  output logic                               out_run_last,
  output logic                               out_frame_end
);
  import fnid_pkg::*;

  localparam int PB    = PIXEL_BITS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SUMW  = PB + 2;
  localparam int DIV_K = SUMW + 1;
  localparam int DIV_M = ((1 << DIV_K) + 2) / 3;
  localparam int PRODW = SUMW + DIV_K;
  localparam int CMPW  = (PB > THRESH_W) ? PB : THRESH_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD0  = 2'd1;
  localparam logic [1:0] ST_RD1  = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  localparam int BIT_ABOVE = 0;
  localparam int BIT_LEFT  = 1;
  localparam int BIT_END   = 2;

  // each entry holds {row two above, row above} for one column
  logic [2*PB-1:0]   line_mem [MAX_WIDTH];
  logic [2*PB-1:0]   rd_data;
  logic [CW-1:0]     rd_addr;

  logic [1:0]        state;
  logic [PB-1:0]     work_pix;
  logic [CW-1:0]     work_col;
  fnid_flags_t       work_flags;
  logic [PB-1:0]     cur_old;
  logic [PB-1:0]     cur_new;
  logic [PB-1:0]     nxt_old;
  logic [PB-1:0]     nxt_new;
  logic [PB-1:0]     prev_pix;
  logic [PB-1:0]     pix1;
  logic [PB-1:0]     pix2;
  logic [2:0]        res_left;

  logic [2:0]        sel_vec;
  logic [2:0]        left_after;
  logic              finish;

  logic [PB-1:0]       center;
  logic [3:0][PB-1:0]  nb;
  logic [3:0]          nb_ok;
  logic [3:0][PB-1:0]  diff;
  logic [3:0]          near;
  logic [SUMW-1:0]     sum;
  logic [2:0]          n_nb;
  logic [PRODW-1:0]    prod3;
  logic [PB-1:0]       avg;
  logic                all_far;

  assign in_pop     = (state == ST_IDLE) && !in_empty;
  assign sel_vec    = res_left & (~res_left + 3'd1);
  assign left_after = res_left & ~sel_vec;
  assign out_push   = (state == ST_RES) && (res_left != '0) && !out_full;
  assign finish     = (state == ST_RES) &&
                      ((res_left == '0) || (out_push && (left_after == '0)));

  always_comb begin
    rd_addr = work_col + CW'(1);
    if (state == ST_IDLE) begin
      if (in_col == '0) begin
        rd_addr = '0;
      end else if (in_flags.has_right) begin
        rd_addr = in_col + CW'(1);
      end else begin
        rd_addr = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= line_mem[rd_addr];
    if (finish) begin
      line_mem[work_col] <= {cur_new, work_pix};
    end
  end

  // neighbours of the pixel being judged: slots are up, down, left, right
  always_comb begin
    center = work_pix;
    nb     = '0;
    nb_ok  = '0;
    if (sel_vec[BIT_ABOVE]) begin
      center   = cur_new;
      nb[0]    = cur_old;
      nb_ok[0] = work_flags.has_up;
      nb[1]    = work_pix;
      nb_ok[1] = 1'b1;
      nb[2]    = prev_pix;
      nb_ok[2] = work_flags.has_left;
      nb[3]    = nxt_new;
      nb_ok[3] = work_flags.has_right;
    end else if (sel_vec[BIT_LEFT]) begin
      // bottom row pixel left of the newest input
      center   = pix1;
      nb[0]    = prev_pix;
      nb_ok[0] = 1'b1;
      nb[2]    = pix2;
      nb_ok[2] = work_flags.has_left2;
      nb[3]    = work_pix;
      nb_ok[3] = 1'b1;
    end else begin
      // bottom right corner
      center   = work_pix;
      nb[0]    = cur_new;
      nb_ok[0] = 1'b1;
      nb[2]    = pix1;
      nb_ok[2] = 1'b1;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      diff[i] = (center > nb[i]) ? (center - nb[i]) : (nb[i] - center);
      near[i] = nb_ok[i] && (CMPW'(diff[i]) <= CMPW'(diff_threshold));
      if (nb_ok[i]) begin
        sum = sum + SUMW'(nb[i]);
      end
    end
    n_nb    = 3'($countones(nb_ok));
    all_far = (nb_ok != '0) && (near == '0);
    // divide by three through a reciprocal, exact for every sum in range
    prod3   = PRODW'(sum + SUMW'(1)) * PRODW'(DIV_M);
    case (n_nb)
      3'd1:    avg = PB'(sum);
      3'd2:    avg = PB'((sum + SUMW'(1)) >> 1);
      3'd3:    avg = PB'(prod3 >> DIV_K);
      3'd4:    avg = PB'((sum + SUMW'(2)) >> 2);
      default: avg = PB'(sum);
    endcase
  end

  assign out_pix       = all_far ? avg : center;
  assign out_replaced  = all_far;
  assign out_run_last  = (left_after == '0);
  assign out_frame_end = sel_vec[BIT_END];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res_left <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!in_empty) begin
            state <= (in_col == '0) ? ST_RD0 : ST_RD1;
          end
        end
        ST_RD0: begin
          state <= ST_RD1;
        end
        ST_RD1: begin
          state    <= ST_RES;
          res_left <= {work_flags.emit_end, work_flags.emit_left, work_flags.emit_above};
        end
        ST_RES: begin
          if (out_push) begin
            res_left <= left_after;
          end
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      work_pix   <= in_pix;
      work_col   <= in_col;
      work_flags <= in_flags;
      // the entry read ahead for the previous column is this column's entry
      cur_old    <= nxt_old;
      cur_new    <= nxt_new;
    end
    if (state == ST_RD0) begin
      {cur_old, cur_new} <= rd_data;
    end
    if (state == ST_RD1) begin
      {nxt_old, nxt_new} <= rd_data;
    end
    if (finish) begin
      if (work_flags.emit_above) begin
        prev_pix <= cur_new;
      end
      pix2 <= pix1;
      pix1 <= work_pix;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_push && out_frame_end) |-> out_run_last)
    else $error("frame end result is not the last of its transaction");

  assert property (@(posedge clk) disable iff (rst)
    (in_pop && (in_col != '0)) |=> (state == ST_RD1))
    else $error("line buffer read ahead skipped for inner column");

  assert property (@(posedge clk) disable iff (rst) in_pop |=> !in_pop)
    else $error("second transaction taken while one is in work");

endmodule

[hdl/four_neighbour_impulse_denoise.sv]
// top level of the four-neighbour impulse denoise filter
//
//  channel   direction  handshake                 payload
//  pixels    in         push / full               pixel_in
//  results   out        pop / empty               pixel_out, was_replaced, run_last, frame_end
//  config    in         cfg_write (no wait)       cfg_index, cfg_data
//
// an item passes the back end through the idle, read and result states, with an extra
// read state at column 0 for the second line buffer read; the single read port of the
// line buffer memory sets this. The back end takes a new item only once the last is done.
// full rises when the 4-entry queue between front and back fills; a pop held low stalls
// the back end through the 4-entry result queue.
// rst clears counters, queues and registers to defaults; the line memory is not cleared.
module four_neighbour_impulse_denoise #(
  parameter int MAX_WIDTH  = fnid_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = fnid_pkg::DEF_PIXEL_BITS,
  parameter int MAX_HEIGHT = fnid_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [fnid_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fnid_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [PIXEL_BITS-1:0]             pixel_in,
  output logic                              empty,
  input  logic                              pop,
  output logic [fnid_pkg::OUT_PIX_W-1:0]    pixel_out,
  output logic                              was_replaced,
  output logic                              run_last,
  output logic                              frame_end
);
  import fnid_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int MID_W = PIXEL_BITS + CW + FLAGS_W;
  localparam int RES_W = PIXEL_BITS + 3;

  logic                  f_push;
  logic                  f_full;
  logic [PIXEL_BITS-1:0] f_pix;
  logic [CW-1:0]         f_col;
  fnid_flags_t           f_flags;
  logic [THRESH_W-1:0]   diff_threshold;

  logic [MID_W-1:0]      mid_din;
  logic [MID_W-1:0]      mid_dout;
  logic                  mid_empty;
  logic                  b_pop;
  logic [PIXEL_BITS-1:0] b_pix;
  logic [CW-1:0]         b_col;
  fnid_flags_t           b_flags;

  logic                  r_full;
  logic                  r_push;
  logic [PIXEL_BITS-1:0] r_pix;
  logic                  r_replaced;
  logic                  r_run_last;
  logic                  r_frame_end;
  logic [RES_W-1:0]      res_din;
  logic [RES_W-1:0]      res_dout;
  logic [PIXEL_BITS-1:0] q_pix_out;

  fnid_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .pixel_in       (pixel_in),
    .q_push         (f_push),
    .q_full         (f_full),
    .q_pix          (f_pix),
    .q_col          (f_col),
    .q_flags        (f_flags),
    .diff_threshold (diff_threshold)
  );

  assign mid_din = {f_pix, f_col, f_flags};
  assign {b_pix, b_col, b_flags} = mid_dout;

  fnid_queue #(
    .DATA_W (MID_W),
    .DEPTH  (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .full  (f_full),
    .din   (mid_din),
    .pop   (b_pop),
    .empty (mid_empty),
    .dout  (mid_dout)
  );

  fnid_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_empty       (mid_empty),
    .in_pop         (b_pop),
    .in_pix         (b_pix),
    .in_col         (b_col),
    .in_flags       (b_flags),
    .diff_threshold (diff_threshold),
    .out_full       (r_full),
    .out_push       (r_push),
    .out_pix        (r_pix),
    .out_replaced   (r_replaced),
    .out_run_last   (r_run_last),
    .out_frame_end  (r_frame_end)
  );

  assign res_din = {r_pix, r_replaced, r_run_last, r_frame_end};

  fnid_queue #(
    .DATA_W (RES_W),
    .DEPTH  (OUT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .full  (r_full),
    .din   (res_din),
    .pop   (pop),
    .empty (empty),
    .dout  (res_dout)
  );

  assign {q_pix_out, was_replaced, run_last, frame_end} = res_dout;
  assign pixel_out = OUT_PIX_W'(q_pix_out);

endmodule

[dv/four_neighbour_impulse_denoise_tb.sv]
// self-checking testbench for the four-neighbour impulse denoise filter
module four_neighbour_impulse_denoise_tb;
  import fnid_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LINE_DEPTH     = DEF_MAX_WIDTH;

  typedef struct packed {
    logic [OUT_PIX_W-1:0] value;
    logic                 replaced;
    logic                 row_last;
    logic                 frame_last;
  } pixel_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [7:0]             pixel_in = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [OUT_PIX_W-1:0]   pixel_out;
  logic                   was_replaced;
  logic                   run_last;
  logic                   frame_end;

  four_neighbour_impulse_denoise uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .pixel_in     (pixel_in),
    .empty        (empty),
    .pop          (pop),
    .pixel_out    (pixel_out),
    .was_replaced (was_replaced),
    .run_last     (run_last),
    .frame_end    (frame_end)
  );

  always #2 clk = ~clk;

  // filter state mirrored by the predictor
  int         cfg_width  = IMAGE_WIDTH_RESET;
  int         cfg_height = IMAGE_HEIGHT_RESET;
  int         cfg_thresh = THRESH_RESET;
  logic [7:0] older_row[LINE_DEPTH];
  logic [7:0] newer_row[LINE_DEPTH];
  int         row_pos = 0;
  int         col_pos = 0;
  int         left_above = 0;

  logic [7:0]    frame_pixels[$];
  pixel_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int smooth_level = 128;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int replaced_seen = 0;
  int settings_count = 0;

  function automatic pixel_result_t judge_pixel(input int center, input int n, input int n0,
                                                input int n1, input int n2, input int n3);
    int            nbv[4];
    int            sum;
    int            diff;
    logic          all_far;
    pixel_result_t res;
    nbv[0] = n0;
    nbv[1] = n1;
    nbv[2] = n2;
    nbv[3] = n3;
    sum = 0;
    all_far = (n > 0);
    for (int i = 0; i < n; i++) begin
      diff = (center > nbv[i]) ? center - nbv[i] : nbv[i] - center;
      if (diff <= cfg_thresh) all_far = 1'b0;
      sum += nbv[i];
    end
    if (all_far) begin
      res.value = 8'((sum + n / 2) / n);
      res.replaced = 1'b1;
    end else begin
      res.value = 8'(center);
      res.replaced = 1'b0;
    end
    res.row_last = 1'b0;
    res.frame_last = 1'b0;
    return res;
  endfunction

  task automatic predict_filtered_pixels(input logic [7:0] pix);
    int            w;
    int            h;
    int            r;
    int            c;
    int            n;
    int            k;
    int            center;
    int            nb[4];
    pixel_result_t res[3];
    w = (cfg_width < 2) ? 2 : (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
    h = (cfg_height < 2) ? 2 : (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height;
    r = (row_pos >= h) ? 0 : row_pos;
    c = (col_pos >= w) ? 0 : col_pos;
    k = 0;
    nb = '{0, 0, 0, 0};
    // the row above is complete once the pixel below it arrives
    if (r >= 1) begin
      center = int'(newer_row[c]);
      n = 0;
      if (r >= 2) begin
        nb[n] = int'(older_row[c]);
        n++;
      end
      nb[n] = int'(pix);
      n++;
      if (c >= 1) begin
        nb[n] = left_above;
        n++;
      end
      if (c + 1 < w) begin
        nb[n] = int'(newer_row[c + 1]);
        n++;
      end
      res[k] = judge_pixel(center, n, nb[0], nb[1], nb[2], nb[3]);
      k++;
      left_above = center;
    end
    older_row[c] = newer_row[c];
    newer_row[c] = pix;
    // bottom row goes out as soon as its right neighbour is known
    if (r == h - 1) begin
      if (c >= 1) begin
        n = 0;
        nb[n] = int'(older_row[c - 1]);
        n++;
        if (c >= 2) begin
          nb[n] = int'(newer_row[c - 2]);
          n++;
        end
        nb[n] = int'(pix);
        n++;
        res[k] = judge_pixel(int'(newer_row[c - 1]), n, nb[0], nb[1], nb[2], nb[3]);
        k++;
      end
      if (c == w - 1) begin
        res[k] = judge_pixel(int'(newer_row[c]), 2, int'(older_row[c]),
                             int'(newer_row[c - 1]), 0, 0);
        res[k].frame_last = 1'b1;
        k++;
      end
    end
    if (k > 0) res[k - 1].row_last = 1'b1;
    for (int i = 0; i < k; i++) pending_results.push_back(res[i]);
    c++;
    if (c == w) begin
      c = 0;
      r++;
      if (r == h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic check_result();
    pixel_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: pixel_out %0d", pixel_out);
      mismatch_count++;
    end else begin
      exp_res = pending_results.pop_front();
      if (pixel_out !== exp_res.value) begin
        $error("pixel_out: expected %0d, actual %0d", exp_res.value, pixel_out);
        mismatch_count++;
      end
      if (was_replaced !== exp_res.replaced) begin
        $error("was_replaced: expected %0d, actual %0d", exp_res.replaced, was_replaced);
        mismatch_count++;
      end
      if (run_last !== exp_res.row_last) begin
        $error("run_last: expected %0d, actual %0d", exp_res.row_last, run_last);
        mismatch_count++;
      end
      if (frame_end !== exp_res.frame_last) begin
        $error("frame_end: expected %0d, actual %0d", exp_res.frame_last, frame_end);
        mismatch_count++;
      end
    end
    results_seen++;
    if (was_replaced === 1'b1) replaced_seen++;
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        predict_filtered_pixels(pixel_in);
        pixels_sent++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (frame_pixels.size() > 0 && $urandom_range(99) < send_idle_pct) begin
          send_gap = $urandom_range(14);
          push <= 1'b0;
        end else if (frame_pixels.size() > 0) begin
          push <= 1'b1;
          pixel_in <= frame_pixels.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      recv_gap = 0;
    end else begin
      if (pop && !empty) check_result();
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if ($urandom_range(99) < recv_idle_pct) begin
        recv_gap = $urandom_range(14);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    logic restart;
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    restart = 1'b1;
    case (idx)
      REG_IMAGE_WIDTH:    cfg_width = value % (1 << IMAGE_WIDTH_W);
      REG_IMAGE_HEIGHT:   cfg_height = value % (1 << IMAGE_HEIGHT_W);
      REG_DIFF_THRESHOLD: cfg_thresh = value % (1 << THRESH_W);
      default:            restart = 1'b0;
    endcase
    if (restart) begin
      row_pos = 0;
      col_pos = 0;
      left_above = 0;
    end
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_count++;
    @(negedge clk);
  endtask

  task automatic pick_idling(input logic allow);
    send_idle_pct = allow ? $urandom_range(2) * 12 : 0;
    recv_idle_pct = allow ? $urandom_range(2) * 12 : 0;
  endtask

  // mostly smooth content with impulses, some plain noise
  task automatic queue_pixels(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        smooth_level += int'($urandom_range(6)) - 3;
        if (smooth_level < 0) smooth_level = 0;
        if (smooth_level > 255) smooth_level = 255;
        frame_pixels.push_back(8'(smooth_level));
      end else if (pick < 75) begin
        frame_pixels.push_back($urandom_range(1) ? 8'(255 - $urandom_range(10)) :
                                                   8'($urandom_range(10)));
      end else begin
        frame_pixels.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_results_done();
    while (frame_pixels.size() != 0 || push || pending_results.size() != 0) @(negedge clk);
  endtask

  // rows that give no result may still be in flight after the last result
  task automatic settle();
    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int w, input int h, input int thresh, input int count,
                              input logic allow_idle);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_DIFF_THRESHOLD, thresh);
    finish_writes();
    pick_idling(allow_idle);
    queue_pixels(count);
    settle();
  endtask

  initial begin
    logic [7:0] spike_frames[18];
    logic [7:0] rounding_frame[4];
    spike_frames = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
                     8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    rounding_frame = '{8'd100, 8'd0, 8'd1, 8'd200};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults straight out of reset
    pick_idling(1'b1);
    queue_pixels(40);
    settle();

    // lone spike then checkerboard at zero threshold, equal neighbours count as close
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_DIFF_THRESHOLD, 0);
    finish_writes();
    foreach (spike_frames[i]) frame_pixels.push_back(spike_frames[i]);
    settle();
    // smallest frame, averages that round half up
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    finish_writes();
    foreach (rounding_frame[i]) frame_pixels.push_back(rounding_frame[i]);
    settle();

    // sizes below the minimum act as 2x2
    random_phase(0, 1, $urandom_range(40), 24, 1'b1);
    random_phase(5, 4, 3, 40, 1'b1);
    random_phase(4, 8191, 255, 30, 1'b1);
    // a write to an unused index must not restart the frame
    write_reg(REG_UNUSED, (1 << CFG_DATA_W) - 1);
    finish_writes();
    queue_pixels(20);
    settle();

    // sender holds off mid-frame until everything has drained
    write_reg(REG_IMAGE_WIDTH, 7);
    write_reg(REG_IMAGE_HEIGHT, 4096);
    write_reg(REG_DIFF_THRESHOLD, $urandom_range(20));
    finish_writes();
    pick_idling(1'b1);
    queue_pixels(20);
    wait_results_done();
    queue_pixels(20);
    settle();

    random_phase(9, 2, 10, 18, 1'b1);
    random_phase(6, 3, $urandom_range(30), 36, 1'b0);

    $display("covered %0d pixels and %0d results (%0d replaced) over %0d register settings",
             pixels_sent, results_seen, replaced_seen, settings_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[four_neighbour_impulse_denoise.f]
hdl/fnid_pkg.sv
hdl/fnid_queue.sv
hdl/fnid_front.sv
hdl/fnid_back.sv
hdl/four_neighbour_impulse_denoise.sv
dv/four_neighbour_impulse_denoise_tb.sv
